[sv/kwc_pkg.sv]
// ----------------------------------------------------------------------------
// kwc_pkg
// Shared widths, mode codes and link types for the keyword cipher.
// ----------------------------------------------------------------------------
package kwc_pkg;

   localparam int NUM_LETTERS = 26;
   localparam int LETTER_W    = $clog2(NUM_LETTERS + 1);
   localparam int CHAR_W      = 8;
   localparam int MODE_W      = 3;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [MODE_W-1:0]   mode_type;

   localparam letter_type LETTER_COUNT = letter_type'(NUM_LETTERS);
   localparam letter_type LAST_LETTER  = letter_type'(NUM_LETTERS - 1);

   localparam mode_type MODE_CLEAR   = 3'd0;
   localparam mode_type MODE_KEY     = 3'd1;
   localparam mode_type MODE_FINISH  = 3'd2;
   localparam mode_type MODE_ENCRYPT = 3'd3;
   localparam mode_type MODE_DECRYPT = 3'd4;

   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_UPPER_Z = 8'h5A;
   localparam char_type CHAR_LOWER_A = 8'h61;
   localparam char_type CHAR_LOWER_Z = 8'h7A;

   // token and running fill count handed from cell to cell
   typedef struct packed {
      logic       tok;
      letter_type cnt;
   } link_type;

   // one alphabet placement: letter goes to slot
   typedef struct packed {
      logic       valid;
      letter_type letter;
      letter_type slot;
   } place_type;

endpackage

[sv/kwc_req_if.sv]
// ----------------------------------------------------------------------------
// kwc_req_if
// Request channel: mode and character word with valid/ready.
// ----------------------------------------------------------------------------
interface kwc_req_if;
   import kwc_pkg::*;

   logic     valid;
   logic     ready;
   mode_type mode;
   char_type char_in;

   modport source (output valid, output mode, output char_in, input ready);
   modport sink   (input valid, input mode, input char_in, output ready);

endinterface

[sv/kwc_rsp_if.sv]
// ----------------------------------------------------------------------------
// kwc_rsp_if
// Response channel: result character and flags with valid/ready.
// ----------------------------------------------------------------------------
interface kwc_rsp_if;
   import kwc_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_out;
   logic     status;
   logic     key_ready;

   modport source (output valid, output char_out, output status, output key_ready,
                   input ready);
   modport sink   (input valid, input char_out, input status, input key_ready,
                   output ready);

endinterface

[sv/kwc_cell.sv]
// ----------------------------------------------------------------------------
// kwc_cell
// One letter cell: forward entry for slot id, inverse entry and used bit for
// letter id, and one stage of the finish token chain.
// ----------------------------------------------------------------------------
module kwc_cell (
   input  logic                clock,
   input  logic                reset,
   input  kwc_pkg::letter_type id,
   input  logic                clear,
   input  kwc_pkg::place_type  place,
   input  kwc_pkg::link_type   left_link,
   output kwc_pkg::link_type   right_link,
   output kwc_pkg::place_type  walk_req,
   output logic                used,
   output kwc_pkg::letter_type fwd,
   output kwc_pkg::letter_type inv
);
   import kwc_pkg::*;

   logic       used_ff, used_in;
   letter_type fwd_ff, fwd_in;
   letter_type inv_ff, inv_in;
   link_type   link_ff, link_in;
   logic       take;

   always_comb begin
      take = left_link.tok && !used_ff && (left_link.cnt < LETTER_COUNT);

      walk_req.valid  = take;
      walk_req.letter = id;
      walk_req.slot   = left_link.cnt;

      link_in.tok = left_link.tok;
      link_in.cnt = take ? left_link.cnt + letter_type'(1) : left_link.cnt;

      used_in = used_ff;
      inv_in  = inv_ff;
      fwd_in  = fwd_ff;
      if (clear) begin
         used_in = 1'b0;
      end else if (place.valid && place.letter == id) begin
         used_in = 1'b1;
         inv_in  = place.slot;
      end
      if (place.valid && place.slot == id) begin
         fwd_in = place.letter;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff      <= fwd_in;
      inv_ff      <= inv_in;
      link_ff.cnt <= link_in.cnt;
      if (reset) begin
         used_ff     <= 1'b0;
         link_ff.tok <= 1'b0;
      end else begin
         used_ff     <= used_in;
         link_ff.tok <= link_in.tok;
      end
   end

   assign right_link = link_ff;
   assign used       = used_ff;
   assign fwd        = fwd_ff;
   assign inv        = inv_ff;

endmodule

[sv/keyword_substitution_cipher.sv]
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword substitution cipher built on a row of 26 letter cells.
//
// Clear, key character, encrypt, decrypt and the unused modes may follow one
// another in consecutive cycles; each result sits in an output register, so
// a new word is taken only while that register is empty or in the cycle its
// result is taken by the sink.
// Finish occupies the block while a token walks the 26 letter cells, one cell
// per cycle, placing every unused letter at the running fill count, and the
// result is issued once the walk ends and the output register is free.
// The cipher alphabet lives in the cells; a lookup reads one cell entry.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher (
   input  logic      clock,
   input  logic      reset,
   kwc_req_if.sink   req_bus,
   kwc_rsp_if.source rsp_bus
);
   import kwc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_type;

   state_type  state_ff, state_in;
   letter_type fill_ff, fill_in;
   logic       ready_flag_ff, ready_flag_in;
   logic       start_ff, start_in;
   char_type   hold_char_ff, hold_char_in;
   logic       rsp_valid_ff, rsp_valid_in;
   char_type   rsp_char_ff, rsp_char_in;
   logic       rsp_status_ff, rsp_status_in;
   logic       rsp_key_ready_ff, rsp_key_ready_in;

   link_type   links [NUM_LETTERS];
   place_type  walk_reqs [NUM_LETTERS];
   logic       cell_used [NUM_LETTERS];
   letter_type cell_fwd [NUM_LETTERS];
   letter_type cell_inv [NUM_LETTERS];
   logic [NUM_LETTERS-1:0] walk_valid_vec;

   link_type   start_link;
   place_type  walk_place, key_place, place;
   logic       accept, clear, rsp_free;
   logic       is_upper, is_lower, is_letter;
   letter_type idx, lookup;
   char_type   cipher_char;

   always_comb begin
      accept    = req_bus.valid && req_bus.ready;
      is_upper  = (req_bus.char_in >= CHAR_UPPER_A) && (req_bus.char_in <= CHAR_UPPER_Z);
      is_lower  = (req_bus.char_in >= CHAR_LOWER_A) && (req_bus.char_in <= CHAR_LOWER_Z);
      is_letter = is_upper || is_lower;
      if (is_upper) begin
         idx = letter_type'(req_bus.char_in - CHAR_UPPER_A);
      end else if (is_lower) begin
         idx = letter_type'(req_bus.char_in - CHAR_LOWER_A);
      end else begin
         idx = '0;
      end
   end

   assign start_link.tok = start_ff;
   assign start_link.cnt = fill_ff;

   for (genvar g = 0; g < NUM_LETTERS; g++) begin : g_cell
      if (g == 0) begin : g_head
         kwc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .id         (letter_type'(g)),
            .clear      (clear),
            .place      (place),
            .left_link  (start_link),
            .right_link (links[g]),
            .walk_req   (walk_reqs[g]),
            .used       (cell_used[g]),
            .fwd        (cell_fwd[g]),
            .inv        (cell_inv[g])
         );
      end else begin : g_body
         kwc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .id         (letter_type'(g)),
            .clear      (clear),
            .place      (place),
            .left_link  (links[g-1]),
            .right_link (links[g]),
            .walk_req   (walk_reqs[g]),
            .used       (cell_used[g]),
            .fwd        (cell_fwd[g]),
            .inv        (cell_inv[g])
         );
      end
      assign walk_valid_vec[g] = walk_reqs[g].valid;
   end

   always_comb begin
      walk_place = '0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (walk_reqs[i].valid) begin
            walk_place = walk_reqs[i];
         end
      end
   end

   always_comb begin
      key_place.valid  = accept && (req_bus.mode == MODE_KEY) && is_letter
                         && !cell_used[idx] && (fill_ff < LETTER_COUNT);
      key_place.letter = idx;
      key_place.slot   = fill_ff;
      place            = (state_ff == S_WALK) ? walk_place : key_place;
      clear            = accept && (req_bus.mode == MODE_CLEAR);
   end

   always_comb begin
      lookup = (req_bus.mode == MODE_ENCRYPT) ? cell_fwd[idx] : cell_inv[idx];
      if (lookup >= LETTER_COUNT) begin
         lookup = LAST_LETTER;
      end
      cipher_char = (is_upper ? CHAR_UPPER_A : CHAR_LOWER_A) + char_type'(lookup);
   end

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && rsp_free;

   always_comb begin
      state_in         = state_ff;
      fill_in          = fill_ff;
      ready_flag_in    = ready_flag_ff;
      start_in         = 1'b0;
      hold_char_in     = hold_char_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in      = rsp_char_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_key_ready_in = rsp_key_ready_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in     = 1'b1;
               rsp_char_in      = req_bus.char_in;
               rsp_status_in    = 1'b0;
               rsp_key_ready_in = ready_flag_ff;
               case (req_bus.mode)
                  MODE_CLEAR: begin
                     fill_in          = '0;
                     ready_flag_in    = 1'b0;
                     rsp_key_ready_in = 1'b0;
                  end
                  MODE_KEY: begin
                     if (key_place.valid) begin
                        fill_in = fill_ff + letter_type'(1);
                     end
                  end
                  MODE_FINISH: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
                     rsp_char_in  = rsp_char_ff;
                     start_in     = 1'b1;
                     hold_char_in = req_bus.char_in;
                     state_in     = S_WALK;
                  end
                  MODE_ENCRYPT, MODE_DECRYPT: begin
                     if (!ready_flag_ff) begin
                        rsp_status_in = 1'b1;
                     end else if (is_letter) begin
                        rsp_char_in = cipher_char;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (links[NUM_LETTERS-1].tok) begin
               fill_in       = links[NUM_LETTERS-1].cnt;
               ready_flag_in = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_char_in      = hold_char_ff;
               rsp_status_in    = 1'b0;
               rsp_key_ready_in = ready_flag_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hold_char_ff     <= hold_char_in;
      rsp_char_ff      <= rsp_char_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_key_ready_ff <= rsp_key_ready_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         ready_flag_ff <= 1'b0;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         ready_flag_ff <= ready_flag_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_out  = rsp_char_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.key_ready = rsp_key_ready_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LETTER_COUNT)
      else $error("fill count beyond alphabet size");

   a_walk_one_place: assert property (@(posedge clock) disable iff (reset)
      $onehot0(walk_valid_vec))
      else $error("more than one cell placing a letter");

   a_walk_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && links[NUM_LETTERS-1].tok) |=> ready_flag_ff)
      else $error("finish walk ended without key ready");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_bus.ready)
      else $error("request taken during finish walk");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Keyword cipher bench: builds keys, ciphers text and checks every response
// word against a cycle-free model of the alphabet, with bursty requests and a
// stalling response sink.
// ----------------------------------------------------------------------------
module tb_top;
   import kwc_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int QUIET_LIMIT  = 4000;
   localparam int SETTLE_WAIT  = 40;
   localparam int MAX_REPORTS  = 30;

   typedef struct {
      char_type char_out;
      logic     status;
      logic     key_ready;
   } cipher_word_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic clock;
   logic reset;

   kwc_req_if req_bus ();
   kwc_rsp_if rsp_bus ();

   keyword_substitution_cipher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   letter_type        plain_to_cipher [NUM_LETTERS];
   letter_type        cipher_to_plain [NUM_LETTERS];
   logic [NUM_LETTERS-1:0] used_letters;
   letter_type        fill_slot;
   logic              key_built;

   cipher_word_type pending_words [$];
   cipher_word_type oldest_word;
   int              error_count;
   int              words_sent;
   int              burst_left;
   int              quiet_cycles;
   int              style_left;
   int unsigned     cycle_count;
   stall_kind_type  stall_style;

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   function automatic void place_letter(letter_type idx);
      if (fill_slot < LETTER_COUNT && !used_letters[idx]) begin
         plain_to_cipher[fill_slot] = idx;
         cipher_to_plain[idx] = fill_slot;
         used_letters[idx] = 1'b1;
         fill_slot = fill_slot + letter_type'(1);
      end
   endfunction

   function automatic cipher_word_type cipher_model(mode_type mode, char_type ch);
      cipher_word_type word;
      logic         is_upper;
      logic         is_lower;
      letter_type   idx;
      letter_type   mapped;
      is_upper = ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z;
      is_lower = ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z;
      idx = is_upper ? letter_type'(ch - CHAR_UPPER_A) :
            is_lower ? letter_type'(ch - CHAR_LOWER_A) : '0;
      word.char_out = ch;
      word.status   = 1'b0;
      case (mode)
         MODE_CLEAR: begin
            used_letters = '0;
            fill_slot    = '0;
            key_built    = 1'b0;
         end
         MODE_KEY: begin
            if (is_upper || is_lower)
               place_letter(idx);
         end
         MODE_FINISH: begin
            for (int i = 0; i < NUM_LETTERS; i++)
               place_letter(letter_type'(i));
            key_built = 1'b1;
         end
         MODE_ENCRYPT, MODE_DECRYPT: begin
            if (!key_built) begin
               word.status = 1'b1;
            end else if (is_upper || is_lower) begin
               mapped = (mode == MODE_ENCRYPT) ? plain_to_cipher[idx] : cipher_to_plain[idx];
               word.char_out = (is_upper ? CHAR_UPPER_A : CHAR_LOWER_A) + char_type'(mapped);
            end
         end
         default: ;
      endcase
      word.key_ready = key_built;
      return word;
   endfunction

   function automatic char_type any_letter();
      return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A)
             + char_type'($urandom_range(0, NUM_LETTERS - 1));
   endfunction

   function automatic char_type key_char();
      return ($urandom_range(0, 9) == 0) ? char_type'($urandom_range(0, 255)) : any_letter();
   endfunction

   function automatic char_type text_char();
      return ($urandom_range(0, 9) < 7) ? any_letter() : char_type'($urandom_range(0, 255));
   endfunction

   function automatic mode_type cipher_mode();
      return $urandom_range(0, 1) ? MODE_ENCRYPT : MODE_DECRYPT;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $time);
   endtask

   task automatic send_word(mode_type mode, char_type ch);
      int gap;
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.char_in <= ch;
      do @(posedge clock); while (!req_bus.ready);
      pending_words.push_back(cipher_model(mode, ch));
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // hold requests until every response is back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_cipher_before_key();
      send_word(MODE_ENCRYPT, CHAR_UPPER_A);
      send_word(MODE_DECRYPT, CHAR_LOWER_Z);
      send_word(MODE_ENCRYPT, '0);
      send_word(MODE_DECRYPT, '1);
   endtask

   task automatic test_unused_modes();
      for (int m = MODE_DECRYPT + 1; m < 2 ** MODE_W; m++)
         send_word(mode_type'(m), char_type'($urandom_range(0, 255)));
   endtask

   task automatic test_key_schedule();
      send_word(MODE_CLEAR, CHAR_UPPER_A);
      send_word(MODE_KEY, CHAR_UPPER_Z);
      send_word(MODE_KEY, CHAR_LOWER_A + 8'd4);
      send_word(MODE_KEY, CHAR_LOWER_Z);
      send_word(MODE_KEY, "1");
      send_word(MODE_FINISH, '0);
      send_word(MODE_FINISH, '1);
      send_word(MODE_KEY, CHAR_UPPER_A + 8'd16);
      send_word(MODE_ENCRYPT, CHAR_UPPER_A);
      send_word(MODE_ENCRYPT, CHAR_LOWER_Z);
      send_word(MODE_ENCRYPT, CHAR_UPPER_A - 8'd1);
      send_word(MODE_ENCRYPT, CHAR_UPPER_Z + 8'd1);
      send_word(MODE_ENCRYPT, CHAR_LOWER_A - 8'd1);
      send_word(MODE_ENCRYPT, CHAR_LOWER_Z + 8'd1);
      send_word(MODE_DECRYPT, CHAR_LOWER_A);
      send_word(MODE_DECRYPT, CHAR_UPPER_Z);
      send_word(MODE_CLEAR, '1);
      send_word(MODE_ENCRYPT, CHAR_LOWER_A + 8'd12);
   endtask

   task automatic test_random_traffic();
      int first_word;
      int kind;
      int key_len;
      logic paused;
      first_word = words_sent;
      paused = 1'b0;
      while (words_sent - first_word < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(4, 16))
               send_word(mode_type'($urandom_range(0, 7)), char_type'($urandom_range(0, 255)));
         end else begin
            send_word(MODE_CLEAR, char_type'($urandom_range(0, 255)));
            key_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
            repeat (key_len) send_word(MODE_KEY, key_char());
            if (kind == 1)
               repeat ($urandom_range(1, 4)) send_word(cipher_mode(), text_char());
            if (kind != 2)
               send_word(MODE_FINISH, char_type'($urandom_range(0, 255)));
            repeat ($urandom_range(5, 30)) send_word(cipher_mode(), text_char());
         end
         if (!paused && words_sent - first_word >= RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      error_count = 0;
      words_sent = 0;
      burst_left = 1;
      used_letters = '0;
      fill_slot = '0;
      key_built = 1'b0;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_CLEAR;
      req_bus.char_in <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_cipher_before_key();
      test_unused_modes();
      test_key_schedule();
      test_random_traffic();
      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_style   <= STALL_NONE;
         style_left    <= 0;
         cycle_count   <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (style_left == 0) begin
            stall_style <= stall_kind_type'($urandom_range(0, 3));
            style_left  <= $urandom_range(20, 150);
         end else begin
            style_left <= style_left - 1;
         end
         case (stall_style)
            STALL_NONE:  rsp_bus.ready <= 1'b1;
            STALL_LIGHT: rsp_bus.ready <= ($urandom_range(0, 9) < 7);
            STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_bus.ready <= (cycle_count % 7) < 3;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", int'(rsp_bus.char_out), 0);
         end else begin
            oldest_word = pending_words.pop_front();
            if (rsp_bus.char_out !== oldest_word.char_out)
               report_mismatch("char_out", int'(rsp_bus.char_out),
                               int'(oldest_word.char_out));
            if (rsp_bus.status !== oldest_word.status)
               report_mismatch("status", int'(rsp_bus.status), int'(oldest_word.status));
            if (rsp_bus.key_ready !== oldest_word.key_ready)
               report_mismatch("key_ready", int'(rsp_bus.key_ready),
                               int'(oldest_word.key_ready));
         end
      end
   end

   // drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

endmodule

[sim.f]
sv/kwc_pkg.sv
sv/kwc_req_if.sv
sv/kwc_rsp_if.sv
sv/kwc_cell.sv
sv/keyword_substitution_cipher.sv
bench/tb_top.sv
